FILE: hdl/glu_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// glu_pkg: shared types, codes and microprogram for the gcd/lcm unit
// Holds the control word layout, datapath op codes, jump conditions,
// step addresses and the read-only microprogram table.
// ----------------------------------------------------------------------------
package glu_pkg;

    localparam int unsigned OperandW = 32;
    localparam int unsigned LcmW     = 2 * OperandW;
    localparam int unsigned ShiftW   = $clog2(OperandW);

    typedef logic [3:0] upc_t;
    typedef logic [3:0] uop_t;
    typedef logic [3:0] ucond_t;

    // Datapath operations
    localparam uop_t OP_NOP        = 4'd0;
    localparam uop_t OP_LOAD       = 4'd1;
    localparam uop_t OP_HALVE_BOTH = 4'd2;
    localparam uop_t OP_HALVE_X    = 4'd3;
    localparam uop_t OP_GCD_STEP   = 4'd4;
    localparam uop_t OP_SCALE      = 4'd5;
    localparam uop_t OP_DIV_INIT   = 4'd6;
    localparam uop_t OP_DIV_STEP   = 4'd7;
    localparam uop_t OP_MUL        = 4'd8;
    localparam uop_t OP_FINISH     = 4'd9;

    // Jump conditions, evaluated on the state before the step executes
    localparam ucond_t C_NEXT      = 4'd0;
    localparam ucond_t C_ALWAYS    = 4'd1;
    localparam ucond_t C_NO_INPUT  = 4'd2;
    localparam ucond_t C_INVALID   = 4'd3;
    localparam ucond_t C_BOTH_EVEN = 4'd4;
    localparam ucond_t C_X_EVEN    = 4'd5;
    localparam ucond_t C_Y_NZ      = 4'd6;
    localparam ucond_t C_CNT_NZ    = 4'd7;
    localparam ucond_t C_OUT_BUSY  = 4'd8;

    // Step addresses
    localparam upc_t A_IDLE     = 4'd0;
    localparam upc_t A_CHECK    = 4'd1;
    localparam upc_t A_TZ_BOTH  = 4'd2;
    localparam upc_t A_TZ_X     = 4'd3;
    localparam upc_t A_GCD      = 4'd4;
    localparam upc_t A_SCALE    = 4'd5;
    localparam upc_t A_DIV_INIT = 4'd6;
    localparam upc_t A_DIV      = 4'd7;
    localparam upc_t A_MUL      = 4'd8;
    localparam upc_t A_FINISH   = 4'd9;
    localparam upc_t A_RETURN   = 4'd10;

    typedef struct packed {
        uop_t   op;
        ucond_t cond;
        upc_t   target;
    } uword_t;

    typedef struct packed {
        logic in_valid;
        logic out_free;
        logic invalid;
        logic both_even;
        logic x_even;
        logic y_nz;
        logic cnt_nz;
    } ustat_t;

    function automatic uword_t urom(input upc_t addr);
        uword_t w;
        begin
            unique case (addr)
                A_IDLE:     w = '{OP_LOAD,        C_NO_INPUT,  A_IDLE};
                A_CHECK:    w = '{OP_NOP,         C_INVALID,   A_FINISH};
                A_TZ_BOTH:  w = '{OP_HALVE_BOTH,  C_BOTH_EVEN, A_TZ_BOTH};
                A_TZ_X:     w = '{OP_HALVE_X,     C_X_EVEN,    A_TZ_X};
                A_GCD:      w = '{OP_GCD_STEP,    C_Y_NZ,      A_GCD};
                A_SCALE:    w = '{OP_SCALE,       C_NEXT,      A_IDLE};
                A_DIV_INIT: w = '{OP_DIV_INIT,    C_NEXT,      A_IDLE};
                A_DIV:      w = '{OP_DIV_STEP,    C_CNT_NZ,    A_DIV};
                A_MUL:      w = '{OP_MUL,         C_NEXT,      A_IDLE};
                A_FINISH:   w = '{OP_FINISH,      C_OUT_BUSY,  A_FINISH};
                A_RETURN:   w = '{OP_NOP,         C_ALWAYS,    A_IDLE};
                default:    w = '{OP_NOP,         C_ALWAYS,    A_IDLE};
            endcase
            return w;
        end
    endfunction

endpackage
`default_nettype wire

FILE: hdl/gcd_lcm_unit_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcd_lcm_unit_core: greatest common divisor and least common multiple
// Top level: sequencer, datapath and output register.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis carries two unsigned 32-bit operands per item.
//   Output stream m_axis carries the gcd, the 64-bit lcm and, on tuser,
//   a flag set when either operand was zero (gcd and lcm are then zero).
//   One item is worked on at a time; s_axis_tready is high only while the
//   sequencer sits at its idle step.
//   A zero operand goes from the check step straight to the finish step.
//   Otherwise the item passes the trailing-zero steps, which strip the
//   zeros shared by both operands and then the extra zeros of the larger
//   operand, the binary gcd steps, the scale step, the serial divider that
//   forms larger/gcd and the multiply step, and then reaches the finish step.
//   After a result is loaded, the sequencer passes its return step and goes
//   back to idle, where it takes the next item.
//   The finished item sits in the output register; the next item can be
//   accepted while it waits. If the receiver stalls, the sequencer holds at
//   its finish step until the register frees up.
//   Reset clears the sequencer to idle and empties the output register.
// ----------------------------------------------------------------------------
module gcd_lcm_unit_core
    import glu_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [63:0]  s_axis_tdata,   // operand_a[31:0], operand_b[63:32]
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [95:0]       m_axis_tdata,   // gcd_value[31:0], lcm_value[95:32]
    output logic              m_axis_tuser    // invalid_operand[0]
);

    uword_t              uword;
    ustat_t              stat;
    logic                idle;
    logic                out_free;
    logic                invalid;
    logic                both_even;
    logic                x_even;
    logic                y_nz;
    logic                cnt_nz;
    logic [OperandW-1:0] gcd_value;
    logic [LcmW-1:0]     lcm_value;

    logic                out_valid_reg, out_valid_next;
    logic [OperandW-1:0] gcd_out_reg;
    logic [LcmW-1:0]     lcm_out_reg;
    logic                inv_out_reg;
    logic                out_load;

    assign out_free = !out_valid_reg || m_axis_tready;
    assign out_load = (uword.op == OP_FINISH) && out_free;

    assign stat = '{
        in_valid:  s_axis_tvalid,
        out_free:  out_free,
        invalid:   invalid,
        both_even: both_even,
        x_even:    x_even,
        y_nz:      y_nz,
        cnt_nz:    cnt_nz
    };

    glu_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .uword (uword),
        .idle  (idle)
    );

    glu_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (uword.op),
        .take      (s_axis_tvalid),
        .operand_a (s_axis_tdata[31:0]),
        .operand_b (s_axis_tdata[63:32]),
        .invalid   (invalid),
        .both_even (both_even),
        .x_even    (x_even),
        .y_nz      (y_nz),
        .cnt_nz    (cnt_nz),
        .gcd_value (gcd_value),
        .lcm_value (lcm_value)
    );

    assign s_axis_tready = idle;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {lcm_out_reg, gcd_out_reg};
    assign m_axis_tuser  = inv_out_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            gcd_out_reg <= gcd_value;
            lcm_out_reg <= lcm_value;
            inv_out_reg <= invalid;
        end
    end

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("second item accepted while one is in progress");

    a_invalid_zeros: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("invalid item carries nonzero results");

    a_valid_gcd_nz: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[31:0] != '0))
        else $error("valid item with zero gcd");
`endif

endmodule
`default_nettype wire

FILE: hdl/glu_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// glu_seq: microcode sequencer
// Step counter, microprogram table lookup and conditional jump logic.
// ----------------------------------------------------------------------------
module glu_seq
    import glu_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire ustat_t stat,
    output uword_t      uword,
    output logic        idle
);

    upc_t pc_reg;
    upc_t pc_next;
    logic jump;

    assign uword = urom(pc_reg);
    assign idle  = (pc_reg == A_IDLE);

    always_comb
    begin
        unique case (uword.cond)
            C_NEXT:      jump = 1'b0;
            C_ALWAYS:    jump = 1'b1;
            C_NO_INPUT:  jump = !stat.in_valid;
            C_INVALID:   jump = stat.invalid;
            C_BOTH_EVEN: jump = stat.both_even;
            C_X_EVEN:    jump = stat.x_even;
            C_Y_NZ:      jump = stat.y_nz;
            C_CNT_NZ:    jump = stat.cnt_nz;
            C_OUT_BUSY:  jump = !stat.out_free;
            default:     jump = 1'b1;
        endcase
        pc_next = jump ? uword.target : upc_t'(pc_reg + 1'b1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= A_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule
`default_nettype wire

FILE: hdl/glu_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// glu_datapath: operand registers, binary gcd, serial divider, multiplier
// Executes one op per cycle as selected by the sequencer's control word.
// ----------------------------------------------------------------------------
module glu_datapath
    import glu_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire uop_t                op,
    input  wire logic                take,
    input  wire logic [OperandW-1:0] operand_a,
    input  wire logic [OperandW-1:0] operand_b,
    output logic                     invalid,
    output logic                     both_even,
    output logic                     x_even,
    output logic                     y_nz,
    output logic                     cnt_nz,
    output logic [OperandW-1:0]      gcd_value,
    output logic [LcmW-1:0]          lcm_value
);

    logic [OperandW-1:0] x_reg, x_next;
    logic [OperandW-1:0] y_reg, y_next;
    logic [OperandW-1:0] big_reg, big_next;
    logic [OperandW-1:0] small_reg, small_next;
    logic [OperandW-1:0] q_reg, q_next;
    logic [OperandW-1:0] r_reg, r_next;
    logic [ShiftW-1:0]   k_reg, k_next;
    logic [ShiftW-1:0]   cnt_reg, cnt_next;
    logic [LcmW-1:0]     lcm_reg, lcm_next;
    logic                inv_reg, inv_next;

    logic                a_ge_b;
    logic [OperandW:0]   rem_shift;
    logic [OperandW:0]   rem_diff;
    logic                rem_ge;
    logic [LcmW-1:0]     product;

    assign a_ge_b    = (operand_a >= operand_b);
    assign rem_shift = {r_reg, q_reg[OperandW-1]};
    assign rem_diff  = rem_shift - {1'b0, x_reg};
    assign rem_ge    = (rem_shift >= {1'b0, x_reg});
    assign product   = LcmW'(q_reg) * LcmW'(small_reg);

    assign invalid   = inv_reg;
    assign both_even = !x_reg[0] && !y_reg[0];
    assign x_even    = !x_reg[0];
    assign y_nz      = |y_reg;
    assign cnt_nz    = |cnt_reg;
    assign gcd_value = inv_reg ? '0 : x_reg;
    assign lcm_value = inv_reg ? '0 : lcm_reg;

    always_comb
    begin
        x_next     = x_reg;
        y_next     = y_reg;
        big_next   = big_reg;
        small_next = small_reg;
        q_next     = q_reg;
        r_next     = r_reg;
        k_next     = k_reg;
        cnt_next   = cnt_reg;
        lcm_next   = lcm_reg;
        inv_next   = inv_reg;
        unique case (op)
            OP_LOAD:
            begin
                if (take)
                begin
                    big_next   = a_ge_b ? operand_a : operand_b;
                    small_next = a_ge_b ? operand_b : operand_a;
                    x_next     = a_ge_b ? operand_a : operand_b;
                    y_next     = a_ge_b ? operand_b : operand_a;
                    k_next     = '0;
                    inv_next   = (operand_a == '0) || (operand_b == '0);
                end
            end
            OP_HALVE_BOTH:
            begin
                // strip common factors of two, count them in k
                if (!x_reg[0] && !y_reg[0])
                begin
                    x_next = x_reg >> 1;
                    y_next = y_reg >> 1;
                    k_next = ShiftW'(k_reg + 1'b1);
                end
            end
            OP_HALVE_X:
            begin
                if (!x_reg[0])
                begin
                    x_next = x_reg >> 1;
                end
            end
            OP_GCD_STEP:
            begin
                // x stays odd; y shrinks until zero
                if (!y_reg[0])
                begin
                    y_next = y_reg >> 1;
                end
                else if (x_reg > y_reg)
                begin
                    x_next = y_reg;
                    y_next = x_reg - y_reg;
                end
                else
                begin
                    y_next = y_reg - x_reg;
                end
            end
            OP_SCALE:
            begin
                x_next = x_reg << k_reg;
            end
            OP_DIV_INIT:
            begin
                q_next   = big_reg;
                r_next   = '0;
                cnt_next = ShiftW'(OperandW - 1);
            end
            OP_DIV_STEP:
            begin
                // restoring division, one quotient bit per step
                r_next   = rem_ge ? rem_diff[OperandW-1:0] : rem_shift[OperandW-1:0];
                q_next   = {q_reg[OperandW-2:0], rem_ge};
                cnt_next = ShiftW'(cnt_reg - 1'b1);
            end
            OP_MUL:
            begin
                lcm_next = product;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_reg <= 1'b0;
            cnt_reg <= '0;
            k_reg   <= '0;
        end
        else
        begin
            inv_reg <= inv_next;
            cnt_reg <= cnt_next;
            k_reg   <= k_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        y_reg     <= y_next;
        big_reg   <= big_next;
        small_reg <= small_next;
        q_reg     <= q_next;
        r_reg     <= r_next;
        lcm_reg   <= lcm_next;
    end

`ifndef SYNTHESIS
    a_gcd_x_odd: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_GCD_STEP) |-> x_reg[0])
        else $error("gcd step entered with even x");

    a_div_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (op == OP_DIV_STEP) |-> (r_reg < x_reg))
        else $error("divider remainder not below divisor");
`endif

endmodule
`default_nettype wire

FILE: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stream-level regression for gcd_lcm_unit_core
// Feeds operand pairs through the input stream, predicts gcd, lcm and the
// zero-operand flag for each accepted pair, and checks every output item in
// order. Random gaps on both sides, a long receiver stall and a full drain.
// ----------------------------------------------------------------------------
module testbench
    import glu_pkg::*;
();

    localparam int IdleLimit  = 4000;
    localparam int TailCycles = 300;

    typedef logic [OperandW-1:0] operand_t;

    typedef struct packed {
        logic [OperandW-1:0] gcd;
        logic [LcmW-1:0]     lcm;
        logic                invalid;
    } pair_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;   // operand_a[31:0], operand_b[63:32]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [95:0] m_axis_tdata;        // gcd_value[31:0], lcm_value[95:32]
    logic        m_axis_tuser;        // invalid_operand[0]

    pair_result_t expected_results[$];
    int           mismatch_count = 0;
    int           idle_cycles = 0;
    bit           source_idles = 1'b1;
    bit           sink_idles = 1'b1;
    int           sink_hold = 0;
    int           sink_wait = 0;

    gcd_lcm_unit_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Euclid on the ordered pair, then lcm as (larger / gcd) * smaller
    function automatic pair_result_t predict_pair(input operand_t a, input operand_t b);
        pair_result_t r;
        operand_t     hi;
        operand_t     lo;
        operand_t     x;
        operand_t     y;
        operand_t     rem;
        logic [LcmW-1:0] quot_w;
        logic [LcmW-1:0] lo_w;
        r = '0;
        if (a == '0 || b == '0)
        begin
            r.invalid = 1'b1;
            return r;
        end
        hi = (a >= b) ? a : b;
        lo = (a >= b) ? b : a;
        x = hi;
        y = lo;
        while (y != '0)
        begin
            rem = x % y;
            x = y;
            y = rem;
        end
        quot_w = hi / x;
        lo_w = lo;
        r.gcd = x;
        r.lcm = quot_w * lo_w;
        return r;
    endfunction

    // Mostly back to back, some short gaps, a few long ones
    function automatic int next_source_gap();
        int r;
        if (!source_idles)
            return 0;
        r = $urandom_range(0, 19);
        if (r < 10)
            return 0;
        else if (r < 18)
            return $urandom_range(1, 4);
        return $urandom_range(20, 80);
    endfunction

    task automatic send_pair(input operand_t a, input operand_t b);
        int gap;
        gap = next_source_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tdata  <= {b, a};
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        expected_results.push_back(predict_pair(a, b));
    endtask

    task automatic end_of_stream();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_for_drain();
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Random operand pair drawn from classes that stress different paths
    task automatic pick_operands(output operand_t a, output operand_t b);
        int       r;
        operand_t g;
        operand_t t;
        r = $urandom_range(0, 99);
        if (r < 30)
        begin
            a = $urandom();
            b = $urandom();
        end
        else if (r < 55)
        begin
            // shared factor, sometimes a large one
            g = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 32'h00FF_FFFF)
                                            : $urandom_range(1, 32'h0000_FFFF);
            a = g * $urandom_range(1, 32'hFFFF_FFFF / g);
            b = g * $urandom_range(1, 32'hFFFF_FFFF / g);
        end
        else if (r < 70)
        begin
            // many trailing zeros on both sides
            a = $urandom_range(1, 255) << $urandom_range(0, 24);
            b = $urandom_range(1, 255) << $urandom_range(0, 24);
        end
        else if (r < 80)
        begin
            a = $urandom_range(1, 1000);
            b = $urandom_range(1, 1000);
        end
        else if (r < 86)
        begin
            a = $urandom_range(1, 32'hFFFF_FFFF);
            b = a;
        end
        else if (r < 93)
        begin
            b = $urandom_range(1, 32'h0000_FFFF);
            a = b * $urandom_range(1, 32'hFFFF_FFFF / b);
        end
        else
        begin
            a = ($urandom_range(0, 3) == 0) ? '0 : $urandom();
            b = '0;
        end
        if ($urandom_range(0, 1) == 1)
        begin
            t = a;
            a = b;
            b = t;
        end
    endtask

    task automatic test_directed_corners();
        send_pair(32'd1, 32'd1);
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_pair(32'hFFFF_FFFF, 32'd1);
        send_pair(32'd1, 32'hFFFF_FFFF);
        send_pair(32'd0, 32'd5);
        send_pair(32'd5, 32'd0);
        send_pair(32'd0, 32'd0);
        send_pair(32'd0, 32'hFFFF_FFFF);
        send_pair(32'hFFFF_FFFF, 32'd0);
        send_pair(32'd12, 32'd18);
        send_pair(32'd18, 32'd12);
        send_pair(32'd7, 32'd7);
        send_pair(32'h8000_0000, 32'h4000_0000);
        send_pair(32'h8000_0000, 32'd3);
        send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFE);
        send_pair(32'hFFFF_FFFB, 32'hFFFF_FFFF);
        send_pair(32'hAAAA_AAAA, 32'h5555_5555);
        send_pair(32'h8000_0000, 32'h8000_0000);
        send_pair(32'd1, 32'h8000_0000);
        send_pair(32'hFFFE_0001, 32'h0000_FFFF);
        send_pair(32'd2, 32'd1);
    endtask

    task automatic test_mixed_random(input int count);
        operand_t a;
        operand_t b;
        for (int i = 0; i < count; i++)
        begin
            pick_operands(a, b);
            send_pair(a, b);
        end
    endtask

    task automatic test_back_to_back();
        source_idles = 1'b0;
        sink_idles   = 1'b0;
        test_mixed_random(200);
        source_idles = 1'b1;
        sink_idles   = 1'b1;
    endtask

    // Receiver holds off while items keep coming, so the input stalls
    task automatic test_output_backpressure();
        @(posedge clk);
        sink_hold = 600;
        source_idles = 1'b0;
        test_mixed_random(12);
        source_idles = 1'b1;
    endtask

    task automatic test_pause_until_drained();
        for (int k = 0; k < 3; k++)
        begin
            test_mixed_random(20);
            end_of_stream();
            wait_for_drain();
        end
    endtask

    // Receiver: random ready with short and occasional long gaps
    always @(negedge clk)
    begin
        if (sink_hold > 0)
        begin
            m_axis_tready <= 1'b0;
            sink_hold = sink_hold - 1;
        end
        else if (sink_wait > 0)
        begin
            m_axis_tready <= 1'b0;
            sink_wait = sink_wait - 1;
        end
        else if (!sink_idles || $urandom_range(0, 3) != 0)
            m_axis_tready <= 1'b1;
        else
        begin
            m_axis_tready <= 1'b0;
            sink_wait = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                   : $urandom_range(0, 2);
        end
    end

    always @(posedge clk)
    begin : check_result
        pair_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result item with no pending pair: gcd %0d lcm %0d invalid %0d",
                       m_axis_tdata[31:0], m_axis_tdata[95:32], m_axis_tuser);
                mismatch_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (m_axis_tdata[31:0] !== want.gcd)
                begin
                    $error("gcd_value: expected %0d, actual %0d", want.gcd, m_axis_tdata[31:0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[95:32] !== want.lcm)
                begin
                    $error("lcm_value: expected %0d, actual %0d", want.lcm,
                           m_axis_tdata[95:32]);
                    mismatch_count++;
                end
                if (m_axis_tuser !== want.invalid)
                begin
                    $error("invalid_operand: expected %0d, actual %0d", want.invalid,
                           m_axis_tuser);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: too long without any item moving on either side
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= IdleLimit)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed_corners();
        test_mixed_random(900);
        test_back_to_back();
        test_output_backpressure();
        test_pause_until_drained();
        test_mixed_random(200);

        end_of_stream();
        wait_for_drain();
        repeat (TailCycles) @(posedge clk);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: filelist.f
hdl/glu_pkg.sv
hdl/glu_seq.sv
hdl/glu_datapath.sv
hdl/gcd_lcm_unit_core.sv
sim/testbench.sv
